/* rtl/mef_pkg.sv */
// Shared types and constants of the majority element finder.
package mef_pkg;

	localparam int unsigned DATA_W = 32;

	// One finished result as it leaves the sequencer.
	typedef struct packed {
		logic              overflow;
		logic              found;
		logic [DATA_W-1:0] value;
	} result_t;

	// Phase of the sequencer, seen by the top level.
	typedef struct packed {
		logic loading;
		logic scanning;
		logic finishing;
	} status_t;

endpackage

/* rtl/majority_element_finder_top.sv */
// Top level of the majority element finder: stream ports and output register.
//
// Usage: a set of signed 32-bit values arrives on the slave stream, one
// item per accepted beat, with s_tlast on the final item of the set.
// While loading, the block stores each value and keeps a vote candidate
// on the fly. After the final item, s_tready drops and a counting pass
// reads the element store once, one entry per cycle through its single
// read port. The one result then goes to the output register and appears
// on the master stream: m_tdata holds the majority value (0 if none),
// m_tuser holds found and overflow. At most MAX_ITEMS items are stored;
// extra items are dropped and set the overflow flag, and the final item
// still closes the set. Reset clears the set state and the output valid
// flag; the store needs no clearing. If the receiver stalls, the result
// waits in the output register while the next set loads; a second result
// waits in the sequencer until the register is free.
module majority_element_finder_top
	import mef_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // majority_value[31:0]
	output logic [1:0]  m_tuser    // found[0], overflow[1]
);

	localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	result_t           res;
	status_t           status;
	logic              slot_free;
	result_t           out_q;
	logic              out_valid_q;

	mef_store #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mef_seq #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.status    (status),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Output register: free when empty or being taken this cycle.
	assign slot_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tuser  = {out_q.overflow, out_q.found};

	// A result is only handed over when the output register can take it.
	a_res_into_free_slot : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result handed over while output register is occupied");

	// A handed-over result is offered on the next cycle.
	a_res_shown : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("result not offered after handover");

	// No item is taken while the counting pass or the handover runs.
	a_no_accept_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(status.scanning || status.finishing) |-> !s_tready)
		else $error("input ready during counting pass");

	// The sequencer is in exactly one phase.
	a_one_phase : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({status.loading, status.scanning, status.finishing}))
		else $error("sequencer phase flags not one-hot");

endmodule

/* rtl/mef_store.sv */
// Element store: one write port and one read port with registered read data.
module mef_store
	import mef_pkg::*;
#(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mef_seq.sv */
// Sequencer: vote while loading, then a counting pass with one shared comparator.
module mef_seq
	import mef_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 1024,
	parameter int unsigned AW        = 10,
	parameter int unsigned CW        = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_value,
	input  logic              in_last,
	input  logic              slot_free,
	output logic              res_valid,
	output result_t           res,
	output status_t           status,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [DATA_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [DATA_W-1:0] mem_rdata
);

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_FINISH} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     vote_q;
	logic [CW-1:0]     hits_q;
	logic [CW-1:0]     idx_q;
	logic [DATA_W-1:0] cand_q;
	logic              ovf_q;
	logic              pend_q;

	logic              accept;
	logic              has_room;
	logic [DATA_W-1:0] cmp_b;
	logic              match;
	logic              ok;

	// The one comparator: input value while loading, stored value while scanning.
	assign cmp_b = (state_q == ST_LOAD) ? in_value : mem_rdata;
	assign match = (cmp_b == cand_q);

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign has_room = (cnt_q < CW'(MAX_ITEMS));

	// Store access.
	assign mem_we    = accept && has_room;
	assign mem_waddr = cnt_q[AW-1:0];
	assign mem_wdata = in_value;
	assign mem_re    = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign mem_raddr = idx_q[AW-1:0];

	// Majority when hits exceed half of the stored count.
	assign ok           = (hits_q > (cnt_q >> 1));
	assign res_valid    = (state_q == ST_FINISH) && slot_free;
	assign res.value    = ok ? cand_q : '0;
	assign res.found    = ok;
	assign res.overflow = ovf_q;

	assign status.loading   = (state_q == ST_LOAD);
	assign status.scanning  = (state_q == ST_SCAN);
	assign status.finishing = (state_q == ST_FINISH);

	// State and set registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			vote_q  <= '0;
			hits_q  <= '0;
			idx_q   <= '0;
			cand_q  <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (has_room) begin
							cnt_q <= cnt_q + 1'b1;
							if (vote_q == '0) begin
								cand_q <= in_value;
								vote_q <= CW'(1);
							end else if (match) begin
								vote_q <= vote_q + 1'b1;
							end else begin
								vote_q <= vote_q - 1'b1;
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
							hits_q  <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					pend_q <= mem_re;
					if (mem_re) begin
						idx_q <= idx_q + 1'b1;
					end
					if (pend_q && match) begin
						hits_q <= hits_q + 1'b1;
					end
					if (!mem_re && !pend_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						vote_q  <= '0;
						cand_q  <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
